// ===== src/pfbe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfbe_pkg
// Shared types and constants for the page frame buffer engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfbe_pkg;

    localparam int PAGES     = 8;
    localparam int COLUMNS   = 128;
    localparam int PG_W      = 3;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 6;
    localparam int MEM_DEPTH = PAGES * COLUMNS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef enum logic [1:0] {
        F_DRAW   = 2'd0,
        F_CLEAR  = 2'd1,
        F_SCROLL = 2'd2,
        F_READ   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_DRAW_WR,
        S_CLEAR,
        S_SC_FIRST,
        S_SC_LOAD,
        S_SC_SHIFT,
        S_SC_LAST,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        WS_ZERO,
        WS_DRAW,
        WS_SHIFT,
        WS_LAST,
        WS_INIT
    } t_wsel;

    typedef enum logic [1:0] {
        COL_HOLD,
        COL_ZERO,
        COL_INC
    } t_colop;

    typedef enum logic [1:0] {
        PG_HOLD,
        PG_FIRST,
        PG_INC
    } t_pgop;

    typedef struct packed {
        logic   capture;
        logic   rd;
        logic   rd_next;
        logic   we;
        t_wsel  wsel;
        t_colop colop;
        t_pgop  pgop;
        logic   cur_load;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  in_mem;
        logic  range_err;
        logic  last_oob;
        logic  page_at_last;
        logic  col_at_last;
        logic  init_last;
        logic  out_free;
    } t_stat;

endpackage

// ===== src/pfbe_datapath.sv =====
// ----------------------------------------------------------------------------
// pfbe_datapath
// Frame memory, item registers, page/column walkers and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfbe_datapath
    import pfbe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [1:0]       i_func,
    input  logic [COL_W-1:0] i_column,
    input  logic [ROW_W-1:0] i_pixel_row,
    input  logic             i_pixel_on,
    input  logic [PG_W-1:0]  i_page_first,
    input  logic [PG_W-1:0]  i_page_last,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [7:0]       o_read_byte,
    output logic             o_range_error
);

    logic [7:0]        r_mem [MEM_DEPTH];
    logic [7:0]        r_rdata;
    t_func             r_func;
    logic [COL_W-1:0]  r_col;
    logic [PG_W-1:0]   r_page;
    logic [PG_W-1:0]   r_first;
    logic [PG_W-1:0]   r_last;
    logic [2:0]        r_bit;
    logic              r_on;
    logic [7:0]        r_cur;
    logic              r_saved;
    logic [ADDR_W-1:0] r_init_addr;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_err;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        draw_mask;
    logic              range_err;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [PG_W-1:0] pg,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(pg) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

    assign range_err = (r_first > r_last);

    always_comb begin
        o_stat.func         = r_func;
        o_stat.in_mem       = (32'(r_page) < PAGES) && (32'(r_col) < COLUMNS);
        o_stat.range_err    = range_err;
        o_stat.last_oob     = (32'(r_last) >= PAGES);
        o_stat.page_at_last = (r_page == r_last);
        o_stat.col_at_last  = (r_col == COL_W'(COLUMNS - 1));
        o_stat.init_last    = (r_init_addr == ADDR_W'(MEM_DEPTH - 1));
        o_stat.out_free     = !r_out_valid || i_ready;
    end

    // scroll reads one page ahead of the page register r_page
    assign rd_addr   = i_cmd.rd_next ? cell_addr(r_page + PG_W'(1), r_col)
                                     : cell_addr(r_page, r_col);
    assign draw_mask = 8'(1) << r_bit;

    always_comb begin
        case (i_cmd.wsel)
            WS_INIT:  wr_addr = r_init_addr;
            WS_SHIFT: wr_addr = cell_addr(r_page - PG_W'(1), r_col);
            default:  wr_addr = cell_addr(r_page, r_col);
        endcase
        case (i_cmd.wsel)
            WS_DRAW:  wr_data = r_on ? (r_rdata | draw_mask) : (r_rdata & ~draw_mask);
            WS_SHIFT: wr_data = {r_rdata[0], r_cur[7:1]};
            WS_LAST:  wr_data = {r_saved, r_cur[7:1]};
            default:  wr_data = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd || i_cmd.rd_next) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= t_func'(i_func);
            r_first <= i_page_first;
            r_last  <= i_page_last;
            r_bit   <= i_pixel_row[2:0];
            r_on    <= i_pixel_on;
            r_page  <= (t_func'(i_func) == F_DRAW) ? i_pixel_row[ROW_W-1:3] : i_page_first;
            r_col   <= i_column;
        end else begin
            case (i_cmd.colop)
                COL_ZERO: r_col <= '0;
                COL_INC:  r_col <= r_col + COL_W'(1);
                default:  r_col <= r_col;
            endcase
            case (i_cmd.pgop)
                PG_FIRST: r_page <= r_first;
                PG_INC:   r_page <= r_page + PG_W'(1);
                default:  r_page <= r_page;
            endcase
        end
        if (i_cmd.cur_load) begin
            r_cur <= r_rdata;
        end
        // first read of a column holds the wrap bit
        if (i_cmd.cur_load && !i_cmd.we) begin
            r_saved <= r_rdata[0];
        end
        if (i_cmd.out_load) begin
            r_out_byte <= (r_func == F_READ && o_stat.in_mem) ? r_rdata : 8'd0;
            r_out_err  <= (r_func == F_CLEAR || r_func == F_SCROLL) && range_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.we && i_cmd.wsel == WS_INIT) begin
                r_init_addr <= r_init_addr + ADDR_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_byte   = r_out_byte;
    assign o_range_error = r_out_err;

endmodule

// ===== src/pfbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfbe_ctrl
// Sequencer for init sweep, draw, clear, scroll and read operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfbe_ctrl
    import pfbe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_ready        = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.rd       = 1'b0;
        o_cmd.rd_next  = 1'b0;
        o_cmd.we       = 1'b0;
        o_cmd.wsel     = WS_ZERO;
        o_cmd.colop    = COL_HOLD;
        o_cmd.pgop     = PG_HOLD;
        o_cmd.cur_load = 1'b0;
        o_cmd.out_load = 1'b0;

        unique case (r_state)
            S_INIT: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = WS_INIT;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.func) inside
                    F_DRAW: begin
                        if (i_stat.in_mem) begin
                            o_cmd.rd = 1'b1;
                            n_state  = S_DRAW_WR;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    F_READ: begin
                        o_cmd.rd = i_stat.in_mem;
                        n_state  = S_DONE;
                    end
                    F_CLEAR, F_SCROLL: begin
                        if (i_stat.range_err || i_stat.last_oob) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.colop = COL_ZERO;
                            n_state     = (i_stat.func == F_CLEAR) ? S_CLEAR : S_SC_FIRST;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_DRAW_WR: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = WS_DRAW;
                n_state    = S_DONE;
            end
            S_CLEAR: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = WS_ZERO;
                if (i_stat.col_at_last) begin
                    o_cmd.colop = COL_ZERO;
                    if (i_stat.page_at_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.pgop = PG_INC;
                    end
                end else begin
                    o_cmd.colop = COL_INC;
                end
            end
            S_SC_FIRST: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SC_LOAD;
            end
            S_SC_LOAD: begin
                o_cmd.cur_load = 1'b1;
                if (i_stat.page_at_last) begin
                    n_state = S_SC_LAST;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    o_cmd.pgop    = PG_INC;
                    n_state       = S_SC_SHIFT;
                end
            end
            S_SC_SHIFT: begin
                o_cmd.we       = 1'b1;
                o_cmd.wsel     = WS_SHIFT;
                o_cmd.cur_load = 1'b1;
                if (i_stat.page_at_last) begin
                    n_state = S_SC_LAST;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    o_cmd.pgop    = PG_INC;
                end
            end
            S_SC_LAST: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = WS_LAST;
                o_cmd.pgop = PG_FIRST;
                if (i_stat.col_at_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.colop = COL_INC;
                    n_state     = S_SC_FIRST;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== src/page_frame_buffer_engine.sv =====
// ----------------------------------------------------------------------------
// page_frame_buffer_engine
// Page-organized monochrome frame buffer, 8 pages by 128 columns.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one operation per transfer: draw
//   pixel, clear page range, scroll page range up with wrap, or read byte.
//   Output channel o_valid/i_ready returns one result per operation:
//   o_read_byte (zero except for reads) and o_range_error.
//   One operation is in progress at a time; o_ready is high only when idle.
//   A read, or a rejected or ignored op, goes from dispatch directly to
//   the result. Clear writes one byte per cycle over the page range;
//   scroll reads and rewrites each byte of the range, column by column.
//   The next input is taken the cycle after the result is loaded. The
//   frame memory has one read port and one write port.
//   After reset the memory is swept to zero, one byte per cycle, with
//   o_ready low. A stalled receiver holds the result in the output
//   register; the engine still accepts one more operation and holds its
//   result until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_frame_buffer_engine
    import pfbe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_func,
    input  logic [COL_W-1:0] i_column,
    input  logic [ROW_W-1:0] i_pixel_row,
    input  logic             i_pixel_on,
    input  logic [PG_W-1:0]  i_page_first,
    input  logic [PG_W-1:0]  i_page_last,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_read_byte,
    output logic             o_range_error
);

    t_cmd  cmd;
    t_stat stat;

    pfbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pfbe_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_func),
        .i_column      (i_column),
        .i_pixel_row   (i_pixel_row),
        .i_pixel_on    (i_pixel_on),
        .i_page_first  (i_page_first),
        .i_page_last   (i_page_last),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_read_byte   (o_read_byte),
        .o_range_error (o_range_error)
    );

endmodule

// ===== src/pfbe_checker.sv =====
// ----------------------------------------------------------------------------
// pfbe_checker
// Port-level checks for the page frame buffer engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfbe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_read_byte,
    input logic       o_range_error
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_byte) && $stable(o_range_error))
        else $error("result changed while stalled");

    // a rejected range never carries read data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_read_byte == 8'd0)
        else $error("range error with nonzero byte");

    // one operation at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after input transfer");

    // no result appears the cycle after an input transfer
    a_min_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !$rose(o_valid))
        else $error("result too early");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind page_frame_buffer_engine pfbe_checker u_pfbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_read_byte   (o_read_byte),
    .o_range_error (o_range_error)
);
